@@ hdl/small_language_tokenizer_top_defines.svh @@
// Assertion macros used by the tokenizer's top-level RTL file.
`ifndef SMALL_LANGUAGE_TOKENIZER_TOP_DEFINES_SVH
`define SMALL_LANGUAGE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/slt_pkg.sv @@
// Types, token kinds and character codes shared by the tokenizer modules.
package slt_pkg;

  localparam int unsigned MaxTokens = 3;
  localparam int unsigned QueueDepth = 8;

  typedef enum logic [3:0] {
    KIND_LPAREN = 4'd0,
    KIND_RPAREN = 4'd1,
    KIND_LBRACE = 4'd2,
    KIND_RBRACE = 4'd3,
    KIND_COMMA  = 4'd4,
    KIND_BANG   = 4'd5,
    KIND_EQUALS = 4'd6,
    KIND_UNDER  = 4'd7,
    KIND_STRING = 4'd8,
    KIND_IDENT  = 4'd9,
    KIND_END    = 4'd10,
    KIND_UNTERM = 4'd11
  } kind_e;

  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEquals = 8'h3d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    logic        run_end;
    logic [15:0] length;
    logic [15:0] start;
    kind_e       kind;
  } token_t;

  // Tokens produced by one source byte, in slot order from slot 0.
  typedef struct packed {
    logic [1:0]                  count;
    token_t [MaxTokens-1:0]      tok;
  } group_t;

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == ChUnder);
  endfunction

  // Returns 1 in bit 4 when the byte is a punctuation token, with its kind below.
  function automatic logic [4:0] punct_lookup(logic [7:0] b);
    logic [4:0] r;
    unique case (b)
      ChLparen: r = {1'b1, KIND_LPAREN};
      ChRparen: r = {1'b1, KIND_RPAREN};
      ChLbrace: r = {1'b1, KIND_LBRACE};
      ChRbrace: r = {1'b1, KIND_RBRACE};
      ChComma:  r = {1'b1, KIND_COMMA};
      ChBang:   r = {1'b1, KIND_BANG};
      ChEquals: r = {1'b1, KIND_EQUALS};
      ChUnder:  r = {1'b1, KIND_UNDER};
      default:  r = {1'b0, KIND_LPAREN};
    endcase
    return r;
  endfunction

endpackage

@@ hdl/small_language_tokenizer_top.sv @@
// Top level of the streaming tokenizer: byte input, token queue and output.
//
// Usage: source bytes arrive on the s_axis channel, one byte per request, with
// tlast marking the final byte of a source. Tokens leave on the m_axis channel,
// one token per request, each carrying its kind, start position and length;
// the token text itself is never sent. m_axis_tlast is high on the last token
// that a given byte produced. A byte produces between zero and three tokens.
// Each accepted byte is scanned in the cycle it is taken, and its tokens are
// written together into an eight-entry token queue, so a token can appear on
// m_axis in the cycle after its byte is accepted. One byte is accepted every
// cycle while the queue has room for three more tokens; unless stalled, output
// drains at one token per cycle, so the sustained rate is one byte per cycle
// whenever bytes average at most one token each, and otherwise is bounded by
// the output port. When the receiver stalls the queue fills and s_axis_tready
// drops once fewer than three entries are free; no token is dropped. After the
// final byte the scan state returns to its reset values, so the next byte
// opens a new source. Reset empties the queue and clears mode, position and
// token start; it takes effect at once and needs no clearing cycles.
`include "small_language_tokenizer_top_defines.svh"

module small_language_tokenizer_top #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                      // [35:20] token_length, [39:36] zero
  output logic        m_axis_tlast    // run_end
);

  localparam int unsigned Depth = slt_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  slt_pkg::group_t grp;
  slt_pkg::token_t mem [Depth];
  slt_pkg::token_t head;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             in_take, out_take;

  // The scanner holds mode, position and the start of the open token.
  slt_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (in_take),
    .src_byte_i   (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .group_o      (grp)
  );

  // Room for a full group of tokens is required before a byte is taken, so the
  // ready does not depend on the incoming byte or on the output handshake.
  assign s_axis_tready = (fill_q <= FillW'(Depth - slt_pkg::MaxTokens));
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != '0);
  assign out_take      = m_axis_tvalid && m_axis_tready;

  assign head          = mem[rd_ptr_q];
  assign m_axis_tdata  = {4'b0, head.length, head.start, head.kind};
  assign m_axis_tlast  = head.run_end;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (in_take) begin
      wr_ptr_d = wr_ptr_q + PtrW'(grp.count);
      fill_d   = fill_d + FillW'(grp.count);
    end
    if (out_take) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      fill_d   = fill_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Token queue storage: the tokens of one byte land in consecutive entries.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(slt_pkg::MaxTokens); i++) begin
      if (in_take && (2'(i) < grp.count)) begin
        mem[wr_ptr_q + PtrW'(i)] <= grp.tok[i];
      end
    end
  end

  // The queue never holds more tokens than it has entries.
  `SLT_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FillW'(Depth), "token queue overfilled")

  // With the output stalled and no byte taken, the queue level holds.
  `SLT_ASSERT_NEXT(a_fill_hold, !in_take && !out_take, $stable(fill_q), "queue level drifted")

  // A final byte always leaves at least its end token waiting.
  `SLT_ASSERT_NEXT(a_end_token, in_take && s_axis_tlast, fill_q != '0, "end token missing")

endmodule

@@ hdl/slt_scan.sv @@
// Scanner state and per-byte token generation for the tokenizer.
module slt_scan #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     src_byte_i,
  input  logic           final_byte_i,
  output slt_pkg::group_t group_o
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_STRING = 2'd2
  } mode_e;

  localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};

  mode_e               mode_q, mode_d, mode_mid;
  logic [POS_BITS-1:0] pos_q, pos_d, begin_q, begin_d, begin_mid, nxt;
  slt_pkg::group_t     grp;
  logic [1:0]          cnt;
  logic                used;
  logic [4:0]          pk;

  // Positions leave the block as their low 16 bits, zero-extended when narrower.
  function automatic logic [15:0] fold16(logic [POS_BITS-1:0] v);
    logic [POS_BITS+15:0] e;
    e = {16'b0, v};
    return e[15:0];
  endfunction

  assign nxt = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
  assign pk  = slt_pkg::punct_lookup(src_byte_i);

  always_comb begin
    grp       = '0;
    cnt       = 2'd0;
    used      = 1'b0;
    mode_mid  = mode_q;
    begin_mid = begin_q;

    unique case (mode_q)
      MODE_IDENT: begin
        if (slt_pkg::is_word(src_byte_i)) begin
          used = 1'b1;
        end else begin
          grp.tok[cnt].kind   = slt_pkg::KIND_IDENT;
          grp.tok[cnt].start  = fold16(begin_q);
          grp.tok[cnt].length = fold16(pos_q - begin_q);
          cnt      = cnt + 2'd1;
          mode_mid = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        used = 1'b1;
        if (src_byte_i == slt_pkg::ChQuote) begin
          grp.tok[cnt].kind   = slt_pkg::KIND_STRING;
          grp.tok[cnt].start  = fold16(begin_q);
          grp.tok[cnt].length = fold16(pos_q - begin_q);
          cnt      = cnt + 2'd1;
          mode_mid = MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (!used) begin
      priority if (pk[4]) begin
        grp.tok[cnt].kind   = slt_pkg::kind_e'(pk[3:0]);
        grp.tok[cnt].start  = fold16(pos_q);
        grp.tok[cnt].length = 16'd1;
        cnt = cnt + 2'd1;
      end else if (src_byte_i == slt_pkg::ChQuote) begin
        mode_mid  = MODE_STRING;
        begin_mid = nxt;
      end else if (slt_pkg::is_letter(src_byte_i)) begin
        mode_mid  = MODE_IDENT;
        begin_mid = pos_q;
      end else begin
        // Spaces and any other byte are skipped.
      end
    end

    mode_d  = mode_mid;
    begin_d = begin_mid;
    pos_d   = nxt;
    if (final_byte_i) begin
      if (mode_mid == MODE_IDENT) begin
        grp.tok[cnt].kind   = slt_pkg::KIND_IDENT;
        grp.tok[cnt].start  = fold16(begin_mid);
        grp.tok[cnt].length = fold16(nxt - begin_mid);
        cnt = cnt + 2'd1;
      end else if (mode_mid == MODE_STRING) begin
        grp.tok[cnt].kind   = slt_pkg::KIND_UNTERM;
        grp.tok[cnt].start  = fold16(begin_mid);
        grp.tok[cnt].length = fold16(nxt - begin_mid);
        cnt = cnt + 2'd1;
      end
      grp.tok[cnt].kind   = slt_pkg::KIND_END;
      grp.tok[cnt].start  = fold16(nxt);
      grp.tok[cnt].length = 16'd0;
      cnt     = cnt + 2'd1;
      mode_d  = MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
    end

    for (int i = 0; i < int'(slt_pkg::MaxTokens); i++) begin
      grp.tok[i].run_end = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
    end
    grp.count = cnt;
  end

  assign group_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      begin_q <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
    end
  end

endmodule

@@ dv/tb_small_language_tokenizer_top.sv @@
// Self-checking testbench for the streaming tokenizer: byte stimulus, prediction and checks.
typedef enum logic [1:0] {
  SCAN_IDLE,
  SCAN_IDENT,
  SCAN_STRING
} scan_e;

// Predicts the tokens of every accepted source byte and checks the tokens that leave the block.
class token_scoreboard;
  scan_e            scan_state = SCAN_IDLE;
  logic [15:0]      cur_pos = '0;
  logic [15:0]      open_start = '0;
  slt_pkg::token_t  expected_tokens[$];
  int               mismatches = 0;

  function logic letter_byte(logic [7:0] b);
    return b inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function logic word_byte(logic [7:0] b);
    return letter_byte(b) || (b inside {[8'h30:8'h39]}) || (b == slt_pkg::ChUnder);
  endfunction

  function logic punct_kind(input logic [7:0] b, output slt_pkg::kind_e k);
    k = slt_pkg::KIND_LPAREN;
    case (b)
      slt_pkg::ChLparen: k = slt_pkg::KIND_LPAREN;
      slt_pkg::ChRparen: k = slt_pkg::KIND_RPAREN;
      slt_pkg::ChLbrace: k = slt_pkg::KIND_LBRACE;
      slt_pkg::ChRbrace: k = slt_pkg::KIND_RBRACE;
      slt_pkg::ChComma:  k = slt_pkg::KIND_COMMA;
      slt_pkg::ChBang:   k = slt_pkg::KIND_BANG;
      slt_pkg::ChEquals: k = slt_pkg::KIND_EQUALS;
      slt_pkg::ChUnder:  k = slt_pkg::KIND_UNDER;
      default:           return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function slt_pkg::token_t make_token(slt_pkg::kind_e k, logic [15:0] start,
                                       logic [15:0] len);
    slt_pkg::token_t t;
    t.kind    = k;
    t.start   = start;
    t.length  = len;
    t.run_end = 1'b0;
    return t;
  endfunction

  // Works out the tokens one accepted source byte causes and queues them in order.
  function void note_byte(logic [7:0] b, logic fin);
    logic [15:0]     p;
    logic [15:0]     nxt;
    logic            consumed;
    slt_pkg::kind_e  pk;
    slt_pkg::token_t group[$];
    p        = cur_pos;
    nxt      = (p == 16'hffff) ? p : p + 16'd1;
    consumed = 1'b0;
    if (scan_state == SCAN_IDENT) begin
      if (word_byte(b)) begin
        consumed = 1'b1;
      end else begin
        // The identifier closes first; the same byte is then scanned afresh.
        group = {group, make_token(slt_pkg::KIND_IDENT, open_start, p - open_start)};
        scan_state = SCAN_IDLE;
      end
    end else if (scan_state == SCAN_STRING) begin
      consumed = 1'b1;
      if (b == slt_pkg::ChQuote) begin
        group = {group, make_token(slt_pkg::KIND_STRING, open_start, p - open_start)};
        scan_state = SCAN_IDLE;
      end
    end
    if (!consumed) begin
      if (punct_kind(b, pk)) begin
        group = {group, make_token(pk, p, 16'd1)};
      end else if (b == slt_pkg::ChQuote) begin
        scan_state = SCAN_STRING;
        open_start = nxt;
      end else if (letter_byte(b)) begin
        scan_state = SCAN_IDENT;
        open_start = p;
      end
    end
    if (fin) begin
      if (scan_state == SCAN_IDENT) begin
        group = {group, make_token(slt_pkg::KIND_IDENT, open_start, nxt - open_start)};
      end else if (scan_state == SCAN_STRING) begin
        group = {group, make_token(slt_pkg::KIND_UNTERM, open_start, nxt - open_start)};
      end
      group = {group, make_token(slt_pkg::KIND_END, nxt, 16'd0)};
      scan_state = SCAN_IDLE;
      cur_pos    = '0;
      open_start = '0;
    end else begin
      cur_pos = nxt;
    end
    foreach (group[i]) begin
      if (i == group.size() - 1) group[i].run_end = 1'b1;
      expected_tokens = {expected_tokens, group[i]};
    end
  endfunction

  task report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  // Compares one token taken from the block with the oldest prediction.
  task check_token(logic [39:0] data, logic last);
    slt_pkg::token_t got;
    slt_pkg::token_t want;
    got = slt_pkg::token_t'({last, data[35:0]});
    if (data[39:36] != 4'd0) report_mismatch("tdata padding", data[39:36], 0);
    if (expected_tokens.size() == 0) begin
      report_mismatch("token kind with no token pending", got.kind, -1);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind != want.kind) report_mismatch("token kind", got.kind, want.kind);
    if (got.start != want.start) report_mismatch("token start", got.start, want.start);
    if (got.length != want.length) report_mismatch("token length", got.length, want.length);
    if (got.run_end != want.run_end) report_mismatch("tlast", got.run_end, want.run_end);
  endtask
endclass

module tb_small_language_tokenizer_top;

  localparam int HoldCycles     = 300;
  localparam int DrainCycles    = 20;
  localparam int WatchdogLimit  = 2000;
  localparam int RandomPerPhase = 120;

  localparam logic [7:0] PunctBytes [8] = '{slt_pkg::ChLparen, slt_pkg::ChRparen,
                                            slt_pkg::ChLbrace, slt_pkg::ChRbrace,
                                            slt_pkg::ChComma, slt_pkg::ChBang,
                                            slt_pkg::ChEquals, slt_pkg::ChUnder};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Letters first, so that indexes 0 to 51 pick a letter that may open an identifier.
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  token_scoreboard sb;
  bit quiet;       // when set, neither side inserts gaps
  bit hold_req;    // asks the receiver for one long hold-off
  bit holding;     // high while that hold-off is in progress
  int idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  small_language_tokenizer_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one source byte and returns at the edge where the request is taken.
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_text(string s, bit closes);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], closes && (i == s.len() - 1));
    end
  endtask

  // One source made mostly of well-formed tokens with random content, some noise bytes,
  // and now and then an identifier or an unclosed string left open on the final byte.
  task automatic send_random_source(inout int sent);
    logic [7:0] src[$];
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: src = {src, PunctBytes[$urandom_range(0, 7)]};
        3, 4: begin
          src = {src, word_chars[$urandom_range(0, 51)]};
          repeat ($urandom_range(0, 6)) src = {src, word_chars[$urandom_range(0, 62)]};
        end
        5, 6: begin
          src = {src, slt_pkg::ChQuote};
          repeat ($urandom_range(0, 6)) begin
            do b = 8'($urandom_range(0, 255)); while (b == slt_pkg::ChQuote);
            src = {src, b};
          end
          src = {src, slt_pkg::ChQuote};
        end
        7: repeat ($urandom_range(1, 3)) src = {src, slt_pkg::ChSpace};
        default: src = {src, 8'($urandom_range(0, 255))};
      endcase
    end
    case ($urandom_range(0, 5))
      0: begin
        src = {src, slt_pkg::ChQuote};
        repeat ($urandom_range(0, 3)) begin
          do b = 8'($urandom_range(0, 255)); while (b == slt_pkg::ChQuote);
          src = {src, b};
        end
      end
      1: src = {src, word_chars[$urandom_range(0, 51)]};
      default: ;
    endcase
    foreach (src[i]) send_byte(src[i], i == src.size() - 1);
    sent += src.size();
  endtask

  task automatic random_phase();
    int sent;
    sent = 0;
    while (sent < RandomPerPhase) begin
      quiet = ($urandom_range(0, 4) == 0);
      send_random_source(sent);
    end
    quiet = 1'b0;
  endtask

  // Accepted requests on both sides feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
  end

  // The watchdog ends a run in which no request is taken on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls and ready stretches, plus one long hold-off on request,
  // counted here, so that the token queue fills and the byte input stalls.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        holding = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holding  = 1'b0;
        hold_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    sb            = new();
    idle_cycles   = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    holding       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed source: every punctuation token, an empty and a filled string, an
    // identifier closed by a quote, a space and a byte with all bits set, then a
    // final byte that closes an identifier and adds its own token and the end token.
    send_text("(){},!=_\"\"Ab9_\"z\" ", 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("k(", 1'b1);
    // An unclosed string on the final byte, a one-letter identifier as a whole source,
    // and a lone opening quote as the final byte.
    send_text("\"q", 1'b1);
    send_text("w", 1'b1);
    send_text("\"", 1'b1);

    random_phase();

    // Back-pressure: the receiver holds off while bytes keep coming without gaps,
    // including bytes that each cause three tokens. The input is withdrawn while
    // waiting so that the last byte is not offered twice.
    s_axis_tvalid <= 1'b0;
    hold_req = 1'b1;
    wait (holding);
    @(posedge clk_i);
    quiet = 1'b1;
    repeat (30) send_byte(PunctBytes[$urandom_range(0, 7)], 1'b0);
    repeat (6) send_text("a(", 1'b1);
    quiet = 1'b0;

    random_phase();

    s_axis_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/slt_pkg.sv
hdl/slt_scan.sv
hdl/small_language_tokenizer_top.sv
dv/tb_small_language_tokenizer_top.sv
